@@ sv/tht_pkg.sv @@
// ----------------------------------------------------------------------------
// tht_pkg
// shared types and constants for the tagged handle table
// ----------------------------------------------------------------------------
package tht_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int HANDLE_W    = 32;
   localparam int PAGE_W      = 16;
   localparam int SLOT_W      = 6;
   localparam int STATUS_W    = 3;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 40;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   typedef enum logic [STATUS_W-1:0] {
      STS_ADDED      = 3'd0,
      STS_PRESENT    = 3'd1,
      STS_FULL       = 3'd2,
      STS_ZERO       = 3'd3,
      STS_FREED      = 3'd4,
      STS_NONE_FREED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [PAGE_W-1:0]   page;
   } entry_type;

   typedef struct packed {
      logic load;
      logic advance;
      logic visit;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic is_release;
      logic hit;
      logic at_end;
      logic out_free;
      logic pend_valid;
   } dp_status_type;

endpackage

@@ sv/tht_ctrl.sv @@
// ----------------------------------------------------------------------------
// tht_ctrl
// sequencer for the table scan: accept, walk slots, deliver final result
// ----------------------------------------------------------------------------
module tht_ctrl
   import tht_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type sts,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      stall;

   assign stall = sts.hit && (!sts.is_release || sts.pend_valid) && !sts.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               if (!sts.is_release && sts.hit) begin
                  state_in = ST_IDLE;
               end else if (sts.at_end) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SCAN: begin
            cmd.visit   = !stall;
            cmd.advance = !stall && !sts.at_end && (sts.is_release || !sts.hit);
         end
         ST_DONE: begin
            cmd.finish = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ sv/tht_datapath.sv @@
// ----------------------------------------------------------------------------
// tht_datapath
// slot memory, occupancy bits, scan compare and result register
// ----------------------------------------------------------------------------
module tht_datapath
   import tht_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         sts,
   input  logic                  req_mode,
   input  logic [HANDLE_W-1:0]   req_handle,
   input  logic [PAGE_W-1:0]     req_page,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [HANDLE_W-1:0]   rsp_handle,
   output logic [SLOT_W-1:0]     rsp_slot,
   output logic                  rsp_last
);

   entry_type table_mem [TABLE_DEPTH];
   entry_type rd_ff;

   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [IDX_W-1:0]       addr_ff;
   logic [IDX_W-1:0]       addr_in;

   logic                   mode_ff;
   logic [HANDLE_W-1:0]    handle_ff;
   logic [PAGE_W-1:0]      page_ff;

   logic                   pend_valid_ff;
   logic [HANDLE_W-1:0]    pend_handle_ff;
   logic [IDX_W-1:0]       pend_slot_ff;
   logic                   free_found_ff;
   logic [IDX_W-1:0]       free_slot_ff;

   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic [HANDLE_W-1:0]    rsp_handle_ff;
   logic [SLOT_W-1:0]      rsp_slot_ff;
   logic                   rsp_last_ff;

   logic                   cur_valid;
   logic                   hit;
   logic                   write_en;
   logic                   emit;
   status_type             emit_status;
   logic [HANDLE_W-1:0]    emit_handle;
   logic [SLOT_W-1:0]      emit_slot;
   logic                   emit_last;

   assign cur_valid = valid_ff[addr_ff];
   assign hit = cur_valid && (mode_ff ? (rd_ff.page == page_ff) : (rd_ff.handle == handle_ff));
   assign write_en = cmd.finish && !mode_ff && (handle_ff != '0) && free_found_ff;

   assign sts.is_release = mode_ff;
   assign sts.hit        = hit;
   assign sts.at_end     = (addr_ff == LAST_IDX);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign sts.pend_valid = pend_valid_ff;

   // next scan address; the memory is read at it so that rd_ff holds the entry at addr_ff
   always_comb begin
      addr_in = addr_ff;
      if (cmd.load || cmd.finish) begin
         addr_in = '0;
      end else if (cmd.advance) begin
         addr_in = addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         table_mem[free_slot_ff] <= '{handle: handle_ff, page: page_ff};
      end
      rd_ff <= table_mem[addr_in];
   end

   always_comb begin
      emit        = 1'b0;
      emit_status = STS_ADDED;
      emit_handle = '0;
      emit_slot   = '0;
      emit_last   = 1'b1;
      if (cmd.visit && hit && !mode_ff) begin
         emit        = 1'b1;
         emit_status = STS_PRESENT;
      end else if (cmd.visit && hit && pend_valid_ff) begin
         emit        = 1'b1;
         emit_status = STS_FREED;
         emit_handle = pend_handle_ff;
         emit_slot   = SLOT_W'(pend_slot_ff);
         emit_last   = 1'b0;
      end else if (cmd.finish) begin
         emit = 1'b1;
         if (!mode_ff) begin
            if (handle_ff == '0) begin
               emit_status = STS_ZERO;
            end else if (free_found_ff) begin
               emit_status = STS_ADDED;
               emit_slot   = SLOT_W'(free_slot_ff);
            end else begin
               emit_status = STS_FULL;
            end
         end else if (pend_valid_ff) begin
            emit_status = STS_FREED;
            emit_handle = pend_handle_ff;
            emit_slot   = SLOT_W'(pend_slot_ff);
         end else begin
            emit_status = STS_NONE_FREED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= '0;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         addr_ff <= addr_in;
         if (cmd.load) begin
            pend_valid_ff <= 1'b0;
            free_found_ff <= 1'b0;
         end
         if (cmd.visit && mode_ff && hit) begin
            pend_valid_ff      <= 1'b1;
            valid_ff[addr_ff]  <= 1'b0;
         end
         if (cmd.visit && !mode_ff && !cur_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
         if (write_en) begin
            valid_ff[free_slot_ff] <= 1'b1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= req_mode;
         handle_ff <= req_handle;
         page_ff   <= req_page;
      end
      if (cmd.visit && mode_ff && hit) begin
         pend_handle_ff <= rd_ff.handle;
         pend_slot_ff   <= addr_ff;
      end
      if (cmd.visit && !mode_ff && !cur_valid && !free_found_ff) begin
         free_slot_ff <= addr_ff;
      end
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_handle_ff <= emit_handle;
         rsp_slot_ff   <= emit_slot;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_handle = rsp_handle_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

@@ sv/tagged_handle_table.sv @@
// ----------------------------------------------------------------------------
// tagged_handle_table
// table of nonzero handles tagged by page; add, duplicate check, release by page
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  req       in   req_tvalid/req_tready  tuser: mode; tdata: handle, page
//  rsp       out  rsp_tvalid/rsp_tready  tuser: status; tdata: freed_handle, slot;
//                                        tlast: last
//
//  a request is accepted in idle, then the scan visits the slots of the slot memory
//  in order, and a closing step delivers the final result
//  an add that finds its handle already present ends at that slot
//  the scan stalls on a match that gives a result while the result register is
//  held, and the closing cycle waits the same way
//  reset clears all occupancy bits at once; no clearing pass is needed
// ----------------------------------------------------------------------------
module tagged_handle_table
   import tht_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // handle[31:0], page[47:32]
   input  logic [0:0]            req_tuser,   // mode[0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // freed_handle[31:0], slot[37:32], zero[39:38]
   output logic [STATUS_W-1:0]   rsp_tuser,   // status[2:0]
   output logic                  rsp_tlast
);

   dp_cmd_type          cmd;
   dp_status_type       sts;
   logic [HANDLE_W-1:0] rsp_handle;
   logic [SLOT_W-1:0]   rsp_slot;

   tht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tht_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_mode   (req_tuser[0]),
      .req_handle (req_tdata[HANDLE_W-1:0]),
      .req_page   (req_tdata[HANDLE_W+PAGE_W-1:HANDLE_W]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_handle (rsp_handle),
      .rsp_slot   (rsp_slot),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_DATA_W-HANDLE_W-SLOT_W){1'b0}}, rsp_slot, rsp_handle};

endmodule

@@ sv/tht_checker.sv @@
// ----------------------------------------------------------------------------
// tht_checker
// port-level checks on the result stream of the tagged handle table
// ----------------------------------------------------------------------------
module tht_checker
   import tht_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]   rsp_tuser,
   input logic                  rsp_tlast
);

   // held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // only freed results can be non-final
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STS_FREED |-> rsp_tlast)
      else $error("non-release result without last");

   // freed handles are never zero, other results carry zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == STS_FREED) == (rsp_tdata[HANDLE_W-1:0] != '0)))
      else $error("freed_handle inconsistent with status");

   // status stays within the defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= STS_NONE_FREED)
      else $error("undefined status code");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind tagged_handle_table tht_checker u_tht_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

@@ verif/tagged_handle_table_tb.sv @@
// ----------------------------------------------------------------------------
// tagged_handle_table_tb
// self-checking bench for the tagged handle table: a scoreboard tracks the
// slot contents, predicts every response of each accepted request and checks
// the responses in order; directed corner requests come first, then random
// fill and mixed add/release traffic under varying backpressure
// ----------------------------------------------------------------------------
module tagged_handle_table_tb
   import tht_pkg::*;
;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 2 * (TABLE_DEPTH + 2);
   localparam logic [PAGE_W-1:0] PAGE_POOL_BASE = 16'h0C40;

   localparam logic MODE_ADD     = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   typedef struct packed {
      status_type          status;
      logic [HANDLE_W-1:0] freed;
      logic [SLOT_W-1:0]   slot;
      logic                last;
   } table_response_type;

   class handle_table_scoreboard;
      logic [HANDLE_W-1:0] handles [TABLE_DEPTH];
      logic [PAGE_W-1:0]   pages [TABLE_DEPTH];
      table_response_type  pending_results [$];
      int errors;
      int requests;
      int responses;
      int full_predicted;
      int status_seen [6];

      function new();
         foreach (handles[i]) begin
            handles[i] = '0;
            pages[i]   = '0;
         end
         foreach (status_seen[i]) status_seen[i] = 0;
         errors         = 0;
         requests       = 0;
         responses      = 0;
         full_predicted = 0;
      endfunction

      function void expect_response(status_type status, logic [HANDLE_W-1:0] freed,
                                    logic [SLOT_W-1:0] slot, logic last);
         table_response_type r;
         r.status = status;
         r.freed  = freed;
         r.slot   = slot;
         r.last   = last;
         pending_results.push_back(r);
      endfunction

      function void note_request(logic mode, logic [HANDLE_W-1:0] h, logic [PAGE_W-1:0] p);
         int  free_slot;
         int  match_count;
         int  k;
         bit  present;
         requests++;
         if (mode == MODE_ADD) begin
            present   = 0;
            free_slot = -1;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (handles[i] == h) present = 1;
               if (free_slot < 0 && handles[i] == '0) free_slot = i;
            end
            if (h == '0) begin
               expect_response(STS_ZERO, '0, '0, 1'b1);
            end else if (present) begin
               expect_response(STS_PRESENT, '0, '0, 1'b1);
            end else if (free_slot < 0) begin
               full_predicted++;
               expect_response(STS_FULL, '0, '0, 1'b1);
            end else begin
               handles[free_slot] = h;
               pages[free_slot]   = p;
               expect_response(STS_ADDED, '0, SLOT_W'(free_slot), 1'b1);
            end
         end else begin
            match_count = 0;
            for (int i = 0; i < TABLE_DEPTH; i++)
               if (handles[i] != '0 && pages[i] == p) match_count++;
            k = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (handles[i] != '0 && pages[i] == p) begin
                  k++;
                  // page tag is left behind, only the handle is cleared
                  expect_response(STS_FREED, handles[i], SLOT_W'(i), k == match_count);
                  handles[i] = '0;
               end
            end
            if (match_count == 0) expect_response(STS_NONE_FREED, '0, '0, 1'b1);
         end
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check_response(logic [STATUS_W-1:0] status, logic [HANDLE_W-1:0] freed,
                          logic [SLOT_W-1:0] slot, logic [1:0] pad, logic last);
         table_response_type exp;
         responses++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected response status %0d handle %h slot %0d",
                                      status, freed, slot));
         end else begin
            exp = pending_results.pop_front();
            if (status < 6) status_seen[status]++;
            if (status != exp.status)
               report_mismatch($sformatf("status %0d, expected %s", status, exp.status.name()));
            if (freed != exp.freed)
               report_mismatch($sformatf("freed handle %h, expected %h", freed, exp.freed));
            if (slot != exp.slot)
               report_mismatch($sformatf("slot %0d, expected %0d", slot, exp.slot));
            if (last != exp.last)
               report_mismatch($sformatf("last %0b, expected %0b", last, exp.last));
            if (pad != 2'b00)
               report_mismatch($sformatf("padding bits %b not zero", pad));
         end
      endtask
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // handle[31:0], page[47:32]
   logic [0:0]            req_tuser  = '0;   // mode[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // freed_handle[31:0], slot[37:32], zero[39:38]
   logic [STATUS_W-1:0]   rsp_tuser;         // status[2:0]
   logic                  rsp_tlast;

   handle_table_scoreboard sb = new();

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  squeeze_req   = 0;
   int  hold_left     = 0;
   int  quiet_cycles  = 0;
   logic [HANDLE_W-1:0] used_handles [$];

   tagged_handle_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // response side backpressure, with one long hold-off on demand
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (squeeze_req) begin
         rsp_tready <= 1'b0;
         hold_left   = HOLD_CYCLES;
         squeeze_req = 0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // handshake monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser[0], req_tdata[HANDLE_W-1:0],
                            req_tdata[HANDLE_W+PAGE_W-1:HANDLE_W]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tuser, rsp_tdata[HANDLE_W-1:0],
                              rsp_tdata[HANDLE_W+SLOT_W-1:HANDLE_W],
                              rsp_tdata[RSP_DATA_W-1:HANDLE_W+SLOT_W], rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic send_request(input logic mode, input logic [HANDLE_W-1:0] h,
                               input logic [PAGE_W-1:0] p);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {p, h};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random(input int release_pct);
      logic                mode;
      logic [HANDLE_W-1:0] h;
      logic [PAGE_W-1:0]   p;
      int                  sel;
      mode = ($urandom_range(0, 99) < release_pct) ? MODE_RELEASE : MODE_ADD;
      sel  = $urandom_range(0, 99);
      if (sel < 6)
         h = '0;
      else if (sel < 24 && used_handles.size() > 0)
         h = used_handles[$urandom_range(0, used_handles.size() - 1)];
      else
         h = $urandom;
      if ($urandom_range(0, 99) < 75)
         p = PAGE_POOL_BASE + PAGE_W'($urandom_range(0, 3));
      else
         p = PAGE_W'($urandom);
      if (mode == MODE_ADD && h != '0) used_handles.push_back(h);
      send_request(mode, h, p);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed corners, no idling
      send_request(MODE_ADD,     32'h0000_0000, 16'h0000);
      send_request(MODE_ADD,     32'hFFFF_FFFF, 16'hFFFF);
      send_request(MODE_ADD,     32'h0000_0001, 16'h0000);
      send_request(MODE_ADD,     32'hFFFF_FFFF, 16'h0005);
      send_request(MODE_ADD,     32'h8000_0000, 16'h8000);
      send_request(MODE_ADD,     32'hA5A5_A5A5, 16'h0001);
      send_request(MODE_RELEASE, 32'h0000_0000, 16'h1234);
      send_request(MODE_RELEASE, 32'h1357_9BDF, 16'hFFFF);
      send_request(MODE_ADD,     32'h5A5A_5A5A, 16'hFFFF);
      send_request(MODE_ADD,     32'hDEAD_BEEF, 16'hFFFF);
      send_request(MODE_RELEASE, 32'hFFFF_FFFF, 16'hFFFF);
      // stale page tags left in cleared slots must not match
      send_request(MODE_RELEASE, 32'h0000_0000, 16'hFFFF);
      send_request(MODE_ADD,     32'h0000_0000, 16'hFFFF);
      send_request(MODE_RELEASE, 32'h0000_0000, 16'h0000);
      send_request(MODE_RELEASE, 32'hFFFF_FFFF, 16'h8000);
      send_request(MODE_RELEASE, 32'h7FFF_FFFE, 16'h0001);

      // fill to full, then mixed traffic
      send_idle_pct = 31;
      recv_idle_pct = 54;
      for (int k = 0; k < 140 && sb.full_predicted < 2; k++) send_random(0);
      repeat (10) send_random(35);

      send_idle_pct = 54;
      recv_idle_pct = 31;
      repeat (60) send_random(45);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      squeeze_req   = 1;
      repeat (40) send_random(30);

      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending_results.size() != 0)
         sb.report_mismatch($sformatf("%0d expected responses never arrived",
                                      sb.pending_results.size()));

      $display("covered %0d requests and %0d responses with %0d mismatches",
               sb.requests, sb.responses, sb.errors);
      $display("added %0d, present %0d, full %0d, zero %0d, freed %0d, nothing freed %0d",
               sb.status_seen[STS_ADDED], sb.status_seen[STS_PRESENT],
               sb.status_seen[STS_FULL], sb.status_seen[STS_ZERO],
               sb.status_seen[STS_FREED], sb.status_seen[STS_NONE_FREED]);
      if (sb.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ tagged_handle_table.f @@
sv/tht_pkg.sv
sv/tht_ctrl.sv
sv/tht_datapath.sv
sv/tagged_handle_table.sv
sv/tht_checker.sv
verif/tagged_handle_table_tb.sv
